### hw/rtl/wfg_pkg.sv
`default_nettype none

package wfg_pkg;

	localparam int CMD_W   = 3;
	localparam int AGENT_W = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD_WAIT    = 3'd0,
		CMD_REMOVE_WAIT = 3'd1,
		CMD_CLEAR_AGENT = 3'd2,
		CMD_REACH_QUERY = 3'd3,
		CMD_SET_FOLLOW  = 3'd4,
		CMD_READ_LEADER = 3'd5
	} cmd_e;

	typedef struct packed {
		logic load;
		logic exec;
		logic step;
		logic finish;
	} wfg_ctl_t;

	typedef struct packed {
		logic needs_search;
		logic front_empty;
	} wfg_sts_t;

endpackage

`default_nettype wire

### hw/rtl/wfg_req_if.sv
`default_nettype none

interface wfg_req_if
	import wfg_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [AGENT_W-1:0] agent_a;
	logic [AGENT_W-1:0] agent_b;
	logic               b_present;

	modport source (output valid, cmd, agent_a, agent_b, b_present, input ready);
	modport sink (input valid, cmd, agent_a, agent_b, b_present, output ready);
endinterface

`default_nettype wire

### hw/rtl/wfg_rsp_if.sv
`default_nettype none

interface wfg_rsp_if
	import wfg_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               ok;
	logic [AGENT_W-1:0] leader;
	logic               leader_valid;

	modport source (output valid, ok, leader, leader_valid, input ready);
	modport sink (input valid, ok, leader, leader_valid, output ready);
endinterface

`default_nettype wire

### hw/rtl/wfg_ctrl.sv
`default_nettype none

module wfg_ctrl
	import wfg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output wfg_ctl_t      ctl,
	input  wire wfg_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   can_finish;

	assign can_finish = !rsp_valid_q || rsp_ready;
	assign req_ready  = (state_q == ST_IDLE);
	assign rsp_valid  = rsp_valid_q;

	always_comb begin
		ctl.load   = (state_q == ST_IDLE) && req_valid;
		ctl.exec   = (state_q == ST_EXEC);
		ctl.step   = (state_q == ST_SEARCH) && !sts.front_empty;
		ctl.finish = (state_q == ST_FINISH) && can_finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready && !ctl.finish) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= sts.needs_search ? ST_SEARCH : ST_FINISH;
				end
				ST_SEARCH: begin
					if (sts.front_empty) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (can_finish) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/wfg_dpath.sv
`default_nettype none

module wfg_dpath
	import wfg_pkg::*;
#(
	parameter int MAX_AGENTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wfg_ctl_t           ctl,
	output wfg_sts_t                sts,
	input  wire logic [CMD_W-1:0]   cmd,
	input  wire logic [AGENT_W-1:0] agent_a,
	input  wire logic [AGENT_W-1:0] agent_b,
	input  wire logic               b_present,
	output logic                    ok,
	output logic [AGENT_W-1:0]      leader,
	output logic                    leader_valid
);

	localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
	localparam logic [MAX_AGENTS-1:0] ONE = {{(MAX_AGENTS-1){1'b0}}, 1'b1};

	typedef logic [MAX_AGENTS-1:0] row_t;

	row_t               rows_q [MAX_AGENTS];
	logic [AGENT_W-1:0] lidx_q [MAX_AGENTS];
	logic [MAX_AGENTS-1:0] lset_q;

	logic [CMD_W-1:0]   cmd_q;
	logic [AGENT_W-1:0] a_q;
	logic [AGENT_W-1:0] b_q;
	logic               bp_q;
	logic               ain_q;
	logic               abin_q;
	logic               same_q;
	row_t               seen_q;
	row_t               front_q;
	logic               ok_q;
	logic [AGENT_W-1:0] leader_q;
	logic               leader_valid_q;

	logic [AW-1:0]      ai;
	row_t               bit_a;
	row_t               bit_b;
	row_t               bit_old;
	row_t               src_bit;
	row_t               next_reach;
	logic               same;
	logic               hit;
	logic               ok_n;
	logic               wr_edge;
	logic               wr_lead;
	logic               lset_n;
	logic [AGENT_W-1:0] lidx_n;

	assign ai      = AW'(a_q);
	assign bit_a   = ONE << a_q;
	assign bit_b   = ONE << b_q;
	assign bit_old = ONE << lidx_q[ai];
	assign src_bit = (cmd_q == CMD_REACH_QUERY) ? bit_a : bit_b;
	assign same    = ain_q && lset_q[ai] && bp_q && (lidx_q[ai] == b_q);
	assign hit     = |(seen_q & ((cmd_q == CMD_REACH_QUERY) ? bit_b : bit_a));

	always_comb begin
		next_reach = '0;
		for (int i = 0; i < MAX_AGENTS; i++) begin
			if (front_q[i]) begin
				next_reach = next_reach | rows_q[i];
			end
		end
	end

	always_comb begin
		sts.front_empty  = (front_q == '0);
		sts.needs_search = 1'b0;
		if (abin_q) begin
			case (cmd_q)
				CMD_ADD_WAIT, CMD_REACH_QUERY: sts.needs_search = 1'b1;
				CMD_SET_FOLLOW:                sts.needs_search = bp_q && !same;
				default:                       sts.needs_search = 1'b0;
			endcase
		end
	end

	always_comb begin
		ok_n    = 1'b0;
		wr_edge = 1'b0;
		wr_lead = 1'b0;
		if (abin_q) begin
			case (cmd_q)
				CMD_ADD_WAIT: begin
					ok_n    = !hit;
					wr_edge = !hit;
				end
				CMD_REACH_QUERY: begin
					ok_n = hit;
				end
				CMD_SET_FOLLOW: begin
					if (same_q || !bp_q) begin
						ok_n = 1'b1;
					end else if (!hit) begin
						ok_n    = 1'b1;
						wr_edge = 1'b1;
						wr_lead = 1'b1;
					end
				end
				default: begin
					ok_n = 1'b0;
				end
			endcase
		end
		lset_n = ain_q && (wr_lead || lset_q[ai]);
		lidx_n = !ain_q ? '0 : (wr_lead ? b_q : lidx_q[ai]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_AGENTS; i++) begin
				rows_q[i] <= '0;
				lidx_q[i] <= '0;
			end
			lset_q <= '0;
		end else begin
			if (ctl.exec && abin_q) begin
				case (cmd_q)
					CMD_REMOVE_WAIT: begin
						rows_q[ai] <= rows_q[ai] & ~bit_b;
					end
					CMD_CLEAR_AGENT: begin
						for (int i = 0; i < MAX_AGENTS; i++) begin
							if (AW'(i) == ai) begin
								rows_q[i] <= '0;
							end else begin
								rows_q[i] <= rows_q[i] & ~bit_a;
							end
						end
					end
					CMD_SET_FOLLOW: begin
						if (!same && lset_q[ai]) begin
							rows_q[ai] <= rows_q[ai] & ~bit_old;
							lset_q[ai] <= 1'b0;
							lidx_q[ai] <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (ctl.finish) begin
				if (wr_edge) begin
					rows_q[ai] <= rows_q[ai] | bit_b;
				end
				if (wr_lead) begin
					lset_q[ai] <= 1'b1;
					lidx_q[ai] <= b_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd;
			a_q    <= agent_a;
			b_q    <= agent_b;
			bp_q   <= b_present;
			ain_q  <= (32'(agent_a) < MAX_AGENTS);
			abin_q <= (32'(agent_a) < MAX_AGENTS) && (32'(agent_b) < MAX_AGENTS);
		end
		if (ctl.exec) begin
			seen_q  <= src_bit;
			front_q <= src_bit;
			same_q  <= same;
		end else if (ctl.step) begin
			front_q <= next_reach & ~seen_q;
			seen_q  <= seen_q | next_reach;
		end
		if (ctl.finish) begin
			ok_q           <= ok_n;
			leader_q       <= lidx_n;
			leader_valid_q <= lset_n;
		end
	end

	assign ok           = ok_q;
	assign leader       = leader_q;
	assign leader_valid = leader_valid_q;

endmodule

`default_nettype wire

### hw/rtl/wait_for_graph_deadlock_guard_unit.sv
`default_nettype none

// Wait-for graph guard over MAX_AGENTS agents: one command in, one response out.
// A wait edge is written only if it cannot close a cycle. Commands are taken one
// at a time: accept, an execute state, then, with both agents in range, for add
// wait, reach query and set follow with a new leader a reachability search over
// the adjacency matrix that expands the frontier one hop per cycle, then a finish
// state that commits and loads the response register; it waits while an earlier
// response is still unaccepted. The next command is taken once the response
// register is loaded.
module wait_for_graph_deadlock_guard_unit
	import wfg_pkg::*;
#(
	parameter int MAX_AGENTS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wfg_req_if.sink   req,
	wfg_rsp_if.source rsp
);

	wfg_ctl_t ctl;
	wfg_sts_t sts;

	wfg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	wfg_dpath #(
		.MAX_AGENTS (MAX_AGENTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cmd          (req.cmd),
		.agent_a      (req.agent_a),
		.agent_b      (req.agent_b),
		.b_present    (req.b_present),
		.ok           (rsp.ok),
		.leader       (rsp.leader),
		.leader_valid (rsp.leader_valid)
	);

endmodule

`default_nettype wire

### verif/tb_wait_for_graph_deadlock_guard_unit.sv
`timescale 1ns / 1ps

module tb_wait_for_graph_deadlock_guard_unit;
	import wfg_pkg::*;

	localparam int NUM_AGENTS = 16;
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	localparam int RANDOM_ITEMS = 400;
	localparam int IDLE_PCT = 30;
	localparam int QUIET_FROM = 200;
	localparam int QUIET_TO = 300;
	localparam int HOLD_AT = 120;
	localparam int HOLD_LEN = 300;
	localparam int STUCK_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [AGENT_W-1:0] a;
		logic [AGENT_W-1:0] b;
		logic               bp;
	} guard_cmd_t;

	typedef struct packed {
		logic               ok;
		logic [AGENT_W-1:0] leader;
		logic               leader_valid;
	} guard_rsp_t;

	logic clk;
	logic arst_n;

	wfg_req_if req();
	wfg_rsp_if rsp();

	wait_for_graph_deadlock_guard_unit #(
		.MAX_AGENTS(NUM_AGENTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	guard_cmd_t pending_cmds[$];
	guard_rsp_t expected_verdicts[$];

	logic [NUM_AGENTS-1:0] wait_mtx [NUM_AGENTS];
	logic [AGENT_W-1:0]    lead_idx [NUM_AGENTS];
	logic                  lead_on [NUM_AGENTS];

	int useful_items;
	int checked;
	int mismatches;
	int stuck;
	int hold_left;
	bit held;
	int cmd_seen [8];
	int adds_written;
	int adds_refused;
	int reach_hits;
	int follows_ok;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic path_exists(logic [AGENT_W-1:0] src, logic [AGENT_W-1:0] dst);
		logic [NUM_AGENTS-1:0] seen;
		logic [NUM_AGENTS-1:0] front;
		logic [NUM_AGENTS-1:0] nxt;
		if (src == dst)
			return 1'b1;
		seen = '0;
		seen[src] = 1'b1;
		front = seen;
		for (int p = 0; p < NUM_AGENTS && front != '0; p++) begin
			nxt = '0;
			for (int i = 0; i < NUM_AGENTS; i++)
				if (front[i])
					nxt |= wait_mtx[i];
			front = nxt & ~seen;
			seen |= nxt;
		end
		return seen[dst];
	endfunction

	function automatic logic try_wait(logic [AGENT_W-1:0] a, logic [AGENT_W-1:0] b);
		if (path_exists(b, a))
			return 1'b0;
		wait_mtx[a][b] = 1'b1;
		return 1'b1;
	endfunction

	function automatic guard_rsp_t apply_command(guard_cmd_t c);
		guard_rsp_t r;
		r.ok = 1'b0;
		case (c.cmd)
			CMD_ADD_WAIT: r.ok = try_wait(c.a, c.b);
			CMD_REMOVE_WAIT: wait_mtx[c.a][c.b] = 1'b0;
			CMD_CLEAR_AGENT: begin
				wait_mtx[c.a] = '0;
				for (int i = 0; i < NUM_AGENTS; i++)
					wait_mtx[i][c.a] = 1'b0;
			end
			CMD_REACH_QUERY: r.ok = path_exists(c.a, c.b);
			CMD_SET_FOLLOW: begin
				if (lead_on[c.a] && c.bp && lead_idx[c.a] == c.b) begin
					r.ok = 1'b1;
				end else begin
					if (lead_on[c.a]) begin
						wait_mtx[c.a][lead_idx[c.a]] = 1'b0;
						lead_on[c.a] = 1'b0;
						lead_idx[c.a] = '0;
					end
					if (!c.bp) begin
						r.ok = 1'b1;
					end else if (try_wait(c.a, c.b)) begin
						lead_idx[c.a] = c.b;
						lead_on[c.a] = 1'b1;
						r.ok = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.leader = lead_on[c.a] ? lead_idx[c.a] : '0;
		r.leader_valid = lead_on[c.a];
		return r;
	endfunction

	function automatic bit idle_now();
		if (checked >= QUIET_FROM && checked < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	function automatic void report_mismatch(string what, int exp_v, int got_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at response %0d: %s expected %0d got %0d",
				checked, what, exp_v, got_v);
	endfunction

	task automatic push_cmd(int cmd, int a, int b, int bp);
		guard_cmd_t c;
		c.cmd = cmd[CMD_W-1:0];
		c.a = a[AGENT_W-1:0];
		c.b = b[AGENT_W-1:0];
		c.bp = bp[0];
		pending_cmds = {pending_cmds, c};
		if (cmd <= int'(CMD_READ_LEADER))
			useful_items++;
	endtask

	task automatic push_chain();
		int perm [NUM_AGENTS];
		int j;
		int t;
		int len;
		int k;
		for (int i = 0; i < NUM_AGENTS; i++)
			perm[i] = i;
		for (int i = NUM_AGENTS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		len = ($urandom_range(9) == 0) ? NUM_AGENTS : $urandom_range(2, 6);
		for (int i = 0; i + 1 < len; i++)
			push_cmd(CMD_ADD_WAIT, perm[i], perm[i+1], $urandom_range(1));
		push_cmd(CMD_ADD_WAIT, perm[len-1], perm[0], $urandom_range(1));
		push_cmd(CMD_REACH_QUERY, perm[0], perm[len-1], $urandom_range(1));
		push_cmd(CMD_REACH_QUERY, perm[len-1], perm[0], $urandom_range(1));
		if (len > 2) begin
			k = $urandom_range(len - 2);
			push_cmd(CMD_REMOVE_WAIT, perm[k], perm[k+1], $urandom_range(1));
			push_cmd(CMD_REACH_QUERY, perm[0], perm[len-1], $urandom_range(1));
			push_cmd(CMD_ADD_WAIT, perm[len-1], perm[0], $urandom_range(1));
		end
	endtask

	task automatic push_follow();
		int a;
		int b;
		int c;
		a = $urandom_range(NUM_AGENTS - 1);
		b = $urandom_range(NUM_AGENTS - 1);
		c = $urandom_range(NUM_AGENTS - 1);
		push_cmd(CMD_SET_FOLLOW, a, b, 1'b1);
		push_cmd(CMD_READ_LEADER, a, c, $urandom_range(1));
		push_cmd(CMD_SET_FOLLOW, a, b, 1'b1);
		push_cmd(CMD_SET_FOLLOW, b, a, 1'b1);
		if ($urandom_range(1))
			push_cmd(CMD_REMOVE_WAIT, a, b, $urandom_range(1));
		push_cmd(CMD_SET_FOLLOW, a, c, $urandom_range(1));
		push_cmd(CMD_REACH_QUERY, a, c, $urandom_range(1));
	endtask

	task automatic push_noise();
		int n;
		int base;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1)) begin
				push_cmd($urandom_range(7), $urandom_range(NUM_AGENTS - 1),
					$urandom_range(NUM_AGENTS - 1), $urandom_range(1));
			end else begin
				base = $urandom_range(NUM_AGENTS - 4);
				push_cmd($urandom_range(CMD_READ_LEADER), base + $urandom_range(3),
					base + $urandom_range(3), $urandom_range(1));
			end
		end
	endtask

	task automatic build_stimulus();
		int r;
		int x;
		push_cmd(CMD_READ_LEADER, 15, 0, 1'b0);
		push_cmd(CMD_ADD_WAIT, 3, 3, 1'b1);
		push_cmd(CMD_REACH_QUERY, 15, 15, 1'b0);
		push_cmd(CMD_SPARE_6, 15, 15, 1'b1);
		push_cmd(CMD_SPARE_7, 0, 0, 1'b0);
		push_cmd(CMD_ADD_WAIT, 0, 1, 1'b0);
		push_cmd(CMD_ADD_WAIT, 1, 2, 1'b0);
		push_cmd(CMD_ADD_WAIT, 2, 0, 1'b0);
		push_cmd(CMD_REACH_QUERY, 0, 2, 1'b0);
		push_cmd(CMD_REACH_QUERY, 2, 0, 1'b0);
		push_cmd(CMD_REMOVE_WAIT, 1, 2, 1'b0);
		push_cmd(CMD_REMOVE_WAIT, 1, 2, 1'b0);
		push_cmd(CMD_REACH_QUERY, 0, 2, 1'b0);
		push_cmd(CMD_SET_FOLLOW, 4, 5, 1'b1);
		push_cmd(CMD_SET_FOLLOW, 4, 5, 1'b1);
		push_cmd(CMD_REMOVE_WAIT, 4, 5, 1'b0);
		push_cmd(CMD_SET_FOLLOW, 4, 5, 1'b1);
		push_cmd(CMD_READ_LEADER, 4, 0, 1'b0);
		push_cmd(CMD_SET_FOLLOW, 6, 7, 1'b1);
		push_cmd(CMD_ADD_WAIT, 7, 8, 1'b0);
		push_cmd(CMD_SET_FOLLOW, 8, 6, 1'b1);
		push_cmd(CMD_SET_FOLLOW, 6, 9, 1'b1);
		push_cmd(CMD_SET_FOLLOW, 6, 0, 1'b0);
		push_cmd(CMD_CLEAR_AGENT, 4, 15, 1'b1);
		push_cmd(CMD_READ_LEADER, 4, 15, 1'b1);
		x = useful_items;
		while (useful_items < x + RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 30) begin
				push_chain();
			end else if (r < 50) begin
				push_follow();
			end else if (r < 58) begin
				push_cmd(CMD_CLEAR_AGENT, $urandom_range(NUM_AGENTS - 1),
					$urandom_range(NUM_AGENTS - 1), $urandom_range(1));
				push_cmd(CMD_REACH_QUERY, $urandom_range(NUM_AGENTS - 1),
					$urandom_range(NUM_AGENTS - 1), $urandom_range(1));
				push_cmd(CMD_READ_LEADER, $urandom_range(NUM_AGENTS - 1),
					$urandom_range(NUM_AGENTS - 1), $urandom_range(1));
			end else if (r < 61) begin
				for (int i = 0; i < NUM_AGENTS; i++)
					push_cmd(CMD_CLEAR_AGENT, i, $urandom_range(NUM_AGENTS - 1), 1'b0);
			end else begin
				push_noise();
			end
		end
	endtask

	// send commands; predict each response at its transfer
	always @(posedge clk or negedge arst_n) begin
		guard_cmd_t taken;
		guard_cmd_t nxt;
		guard_rsp_t verdict;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				taken.cmd = req.cmd;
				taken.a = req.agent_a;
				taken.b = req.agent_b;
				taken.bp = req.b_present;
				verdict = apply_command(taken);
				expected_verdicts = {expected_verdicts, verdict};
				cmd_seen[taken.cmd]++;
				if (taken.cmd == CMD_ADD_WAIT) begin
					if (verdict.ok)
						adds_written++;
					else
						adds_refused++;
				end
				if (taken.cmd == CMD_REACH_QUERY && verdict.ok)
					reach_hits++;
				if (taken.cmd == CMD_SET_FOLLOW && verdict.ok)
					follows_ok++;
			end
			if (!req.valid || req.ready) begin
				if (pending_cmds.size() != 0 && !idle_now()) begin
					nxt = pending_cmds.pop_front();
					req.valid <= 1'b1;
					req.cmd <= nxt.cmd;
					req.agent_a <= nxt.a;
					req.agent_b <= nxt.b;
					req.b_present <= nxt.bp;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// response ready, with one long hold-off to back up the command side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left <= 0;
			held <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else if (!held && checked >= HOLD_AT) begin
			held <= 1'b1;
			hold_left <= HOLD_LEN;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= !idle_now();
		end
	end

	always @(posedge clk) begin
		guard_rsp_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("unexpected response, ok", -1, rsp.ok);
			end else begin
				exp_r = expected_verdicts.pop_front();
				if (rsp.ok !== exp_r.ok)
					report_mismatch("ok", exp_r.ok, rsp.ok);
				if (rsp.leader !== exp_r.leader)
					report_mismatch("leader", exp_r.leader, rsp.leader);
				if (rsp.leader_valid !== exp_r.leader_valid)
					report_mismatch("leader_valid", exp_r.leader_valid, rsp.leader_valid);
			end
			checked++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				stuck <= 0;
			else
				stuck <= stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", stuck);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = '0;
		req.agent_a = '0;
		req.agent_b = '0;
		req.b_present = 1'b0;
		rsp.ready = 1'b0;
		useful_items = 0;
		checked = 0;
		mismatches = 0;
		stuck = 0;
		adds_written = 0;
		adds_refused = 0;
		reach_hits = 0;
		follows_ok = 0;
		for (int i = 0; i < 8; i++)
			cmd_seen[i] = 0;
		for (int i = 0; i < NUM_AGENTS; i++) begin
			wait_mtx[i] = '0;
			lead_idx[i] = '0;
			lead_on[i] = 1'b0;
		end
		build_stimulus();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_cmds.size() != 0 || req.valid)
			@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d responses: add %0d (written %0d, refused %0d), ",
			checked, cmd_seen[CMD_ADD_WAIT], adds_written, adds_refused,
			"remove %0d, clear %0d",
			cmd_seen[CMD_REMOVE_WAIT], cmd_seen[CMD_CLEAR_AGENT]);
		$display("reach %0d (%0d hits), follow %0d (%0d ok), ",
			cmd_seen[CMD_REACH_QUERY], reach_hits, cmd_seen[CMD_SET_FOLLOW], follows_ok,
			"leader reads %0d, spare %0d, mismatches %0d",
			cmd_seen[CMD_READ_LEADER], cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7],
			mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
